[rtl/utf8_to_utf16le_encoder_assert.svh]
// Assertion macros shared by the encoder RTL.
`ifndef UTF8_TO_UTF16LE_ENCODER_ASSERT_SVH
`define UTF8_TO_UTF16LE_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define U8U16_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8U16_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/u8u16_pkg.sv]
// Types and constants shared by the UTF-8 to UTF-16LE encoder.
package u8u16_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // Job kinds handed from the decoder to the serialiser
    localparam logic [1:0] JOB_ERR    = 2'd0;
    localparam logic [1:0] JOB_UNIT   = 2'd1;
    localparam logic [1:0] JOB_PAIR   = 2'd2;

    // Last byte index of each job kind
    localparam logic [1:0] LAST_ERR   = 2'd0;
    localparam logic [1:0] LAST_UNIT  = 2'd1;
    localparam logic [1:0] LAST_PAIR  = 2'd3;

    localparam logic [20:0] CP_MIN_3B   = 21'h000800;
    localparam logic [20:0] CP_MIN_4B   = 21'h010000;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [9:0]  CP_SURR_TOP = 10'h01B;   // 0xD800..0xDFFF >> 11
    localparam logic [15:0] SURR_HI     = 16'hD800;
    localparam logic [15:0] SURR_LO     = 16'hDC00;

    localparam logic [1:0] SEQ_3B = 2'd2;   // continuation count of a 3-byte form
    localparam logic [1:0] SEQ_4B = 2'd3;   // continuation count of a 4-byte form

    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] code;
        logic        eot;
    } job_t;

endpackage

[rtl/u8u16_front.sv]
// Decoder front end: gathers UTF-8 sequences, validates them and queues jobs.
module u8u16_front import u8u16_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_eot,
    output logic       in_ready,
    output logic       push_valid,
    output job_t       push_job,
    input  logic       push_ready
);

    logic [1:0]  pend_reg, pend_next;
    logic [1:0]  seq_reg, seq_next;
    logic [20:0] acc_reg, acc_next;
    logic        failed_reg, failed_next;

    logic        accept;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    always_comb begin
        logic        do_err;
        logic        do_emit;
        logic [20:0] cp;
        logic [1:0]  pend_dec;
        do_err      = 1'b0;
        do_emit     = 1'b0;
        cp          = {acc_reg[14:0], in_byte[5:0]};
        pend_dec    = pend_reg - 2'd1;
        pend_next   = pend_reg;
        seq_next    = seq_reg;
        acc_next    = acc_reg;
        failed_next = failed_reg;
        push_valid  = 1'b0;
        push_job    = '{kind: JOB_ERR, code: '0, eot: in_eot};

        if (accept) begin
            if (failed_reg) begin
                // drop until end of text
                if (in_eot) begin
                    failed_next = 1'b0;
                end
            end else if (pend_reg == 2'd0) begin
                if (!in_byte[7]) begin
                    do_emit = 1'b1;
                    cp      = {13'd0, in_byte};
                end else if (in_byte[7:5] == 3'b110) begin
                    if (in_byte[4:1] == 4'd0 || in_eot) begin
                        do_err = 1'b1;
                    end else begin
                        acc_next  = {16'd0, in_byte[4:0]};
                        pend_next = 2'd1;
                        seq_next  = 2'd1;
                    end
                end else if (in_byte[7:4] == 4'b1110) begin
                    if (in_eot) begin
                        do_err = 1'b1;
                    end else begin
                        acc_next  = {17'd0, in_byte[3:0]};
                        pend_next = 2'd2;
                        seq_next  = 2'd2;
                    end
                end else if (in_byte[7:3] == 5'b11110) begin
                    if (in_eot) begin
                        do_err = 1'b1;
                    end else begin
                        acc_next  = {18'd0, in_byte[2:0]};
                        pend_next = 2'd3;
                        seq_next  = 2'd3;
                    end
                end else begin
                    do_err = 1'b1;
                end
            end else if (in_byte[7:6] != 2'b10) begin
                do_err = 1'b1;
            end else if (pend_dec != 2'd0) begin
                if (in_eot) begin
                    do_err = 1'b1;
                end else begin
                    acc_next  = cp;
                    pend_next = pend_dec;
                end
            end else if ((seq_reg == SEQ_3B && cp < CP_MIN_3B)
                         || (seq_reg == SEQ_4B && cp < CP_MIN_4B)
                         || cp > CP_MAX
                         || cp[20:11] == CP_SURR_TOP) begin
                do_err = 1'b1;
            end else begin
                do_emit = 1'b1;
            end

            if (do_emit) begin
                push_valid    = 1'b1;
                push_job.kind = (cp >= CP_MIN_4B) ? JOB_PAIR : JOB_UNIT;
                push_job.code = cp;
                pend_next     = 2'd0;
                seq_next      = 2'd0;
                acc_next      = '0;
            end

            if (do_err) begin
                push_valid  = 1'b1;
                pend_next   = 2'd0;
                seq_next    = 2'd0;
                acc_next    = '0;
                failed_next = !in_eot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= 2'd0;
            seq_reg    <= 2'd0;
            acc_reg    <= '0;
            failed_reg <= 1'b0;
        end else begin
            pend_reg   <= pend_next;
            seq_reg    <= seq_next;
            acc_reg    <= acc_next;
            failed_reg <= failed_next;
        end
    end

endmodule

[rtl/u8u16_queue.sv]
// Short job queue between decoder and serialiser.
module u8u16_queue import u8u16_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  job_t push_job,
    output logic push_ready,
    output logic pop_valid,
    output job_t pop_job,
    input  logic pop_ready
);

    job_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg, rd_reg;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = count_reg != QUEUE_CW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QUEUE_CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_reg <= wr_reg + QUEUE_AW'(1);
            end
            if (do_pop) begin
                rd_reg <= rd_reg + QUEUE_AW'(1);
            end
        end
    end

endmodule

[rtl/u8u16_back.sv]
// Serialiser back end: turns one job into its UTF-16LE byte transfers.
module u8u16_back import u8u16_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       pop_valid,
    input  job_t       pop_job,
    output logic       pop_ready,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       out_run_last,
    output logic       out_text_done,
    output logic       out_bad,
    input  logic       out_ready
);

    logic        cur_valid_reg;
    job_t        cur_reg;
    logic [1:0]  idx_reg;
    logic [1:0]  last_idx;
    logic        is_last;
    logic [20:0] offs;
    logic [15:0] hi_unit, lo_unit;

    always_comb begin
        case (cur_reg.kind)
            JOB_UNIT: last_idx = LAST_UNIT;
            JOB_PAIR: last_idx = LAST_PAIR;
            default:  last_idx = LAST_ERR;
        endcase
    end

    assign is_last   = idx_reg == last_idx;
    assign pop_ready = !cur_valid_reg || (out_ready && is_last);

    assign offs    = cur_reg.code - CP_MIN_4B;
    assign hi_unit = SURR_HI | {6'd0, offs[19:10]};
    assign lo_unit = SURR_LO | {6'd0, offs[9:0]};

    always_comb begin
        out_byte = 8'd0;
        case (cur_reg.kind)
            JOB_UNIT: out_byte = idx_reg[0] ? cur_reg.code[15:8] : cur_reg.code[7:0];
            JOB_PAIR: begin
                case (idx_reg)
                    2'd0:    out_byte = hi_unit[7:0];
                    2'd1:    out_byte = hi_unit[15:8];
                    2'd2:    out_byte = lo_unit[7:0];
                    default: out_byte = lo_unit[15:8];
                endcase
            end
            default:  out_byte = 8'd0;
        endcase
    end

    assign out_valid     = cur_valid_reg;
    assign out_run_last  = is_last;
    assign out_text_done = is_last && cur_reg.eot;
    assign out_bad       = cur_reg.kind == JOB_ERR;

    // load the next job while no job is held, or as the last byte of the current one transfers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else if (pop_ready) begin
            cur_valid_reg <= pop_valid;
            idx_reg       <= 2'd0;
        end else if (out_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_ready) begin
            cur_reg <= pop_job;
        end
    end

endmodule

[rtl/utf8_to_utf16le_encoder.sv]
// Top level of the UTF-8 to UTF-16LE encoder.
// Takes one UTF-8 byte per transfer (tlast on the final byte of the text) and gives
// UTF-16LE bytes, low byte first, one per transfer. A decoder front end classifies
// each byte combinationally and queues a job (up to four waiting) for a serialiser that
// sends one output byte per cycle while m_tready is high. Sustained rate is therefore set
// by the output: an ASCII byte or a two- or three-byte character gives two output bytes,
// a four-byte character four. Invalid text gives one transfer with tuser bad_text set
// and a zero byte, then input is dropped until end of text. On an idle block the first
// output byte is registered through the queue slot and then the serialiser job register.
`include "utf8_to_utf16le_encoder_assert.svh"

module utf8_to_utf16le_encoder import u8u16_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] run_last, [1] bad_text
    output logic       m_tlast    // text_done
);

    logic push_valid, push_ready;
    job_t push_job;
    logic pop_valid, pop_ready;
    job_t pop_job;

    u8u16_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_eot     (s_tlast),
        .in_ready   (s_tready),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    u8u16_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop_ready  (pop_ready)
    );

    u8u16_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_job       (pop_job),
        .pop_ready     (pop_ready),
        .out_valid     (m_tvalid),
        .out_byte      (m_tdata),
        .out_run_last  (m_tuser[0]),
        .out_text_done (m_tlast),
        .out_bad       (m_tuser[1]),
        .out_ready     (m_tready)
    );

    `U8U16_ASSERT_NEXT(a_idle_back_loads, aclk, aresetn, !m_tvalid && pop_valid, m_tvalid, "serialiser idle while jobs are queued")
    `U8U16_ASSERT_NOW(a_err_single, aclk, aresetn, m_tvalid && m_tuser[1], m_tuser[0] && m_tdata == 8'd0, "error transfer must be a single zero byte")
    `U8U16_ASSERT_NOW(a_done_ends_run, aclk, aresetn, m_tvalid && m_tlast, m_tuser[0], "end of text must close the run")

endmodule
